>>> hw/rtl/rational_arithmetic_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

`define RAU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rational arithmetic unit check failed");

`define RAU_ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("rational arithmetic unit check failed");

`endif

>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned W  = 32;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned CW = $clog2(DW);

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_TOO_WIDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MUL_X = 2'd0,
    MUL_D = 2'd1,
    MUL_Y = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_CHK,
    S_GCD,
    S_DLOAD,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     comb;
    logic     gcd_step;
    logic     div_load;
    logic     div_step;
    logic     finish;
  } rau_cmd_t;

  typedef struct packed {
    logic err_zero;
    logic n_zero;
    logic gcd_done;
    logic div_last;
  } rau_stat_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

endpackage

>>> hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: a beat is taken when start is high and busy is low, and its
// single result appears on the result ports for exactly one cycle with valid_o high; the
// receiver cannot stall, so it must capture the result in that cycle. An item with a zero
// denominator goes from S_MUL0 straight to S_FIN, and an item whose result numerator is
// zero goes from S_CHK to S_FIN; all others form their products in turn on one shared
// 32 by 32 multiplier, then run a binary GCD loop of one shift or subtract-and-shift per
// cycle and a 64-step restoring divider that reduces numerator and denominator side by
// side.
module rational_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic signed [rau_pkg::W-1:0]  a_num_i,
  input  logic signed [rau_pkg::W-1:0]  a_den_i,
  input  logic signed [rau_pkg::W-1:0]  b_num_i,
  input  logic signed [rau_pkg::W-1:0]  b_den_i,
  output logic                          valid_o,
  output logic signed [rau_pkg::W-1:0]  res_num_o,
  output logic [rau_pkg::W-2:0]         res_den_o,
  output logic [1:0]                    status_o
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rau_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .action_i  (action_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .valid_o   (valid_o),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .status_o  (status_o)
  );

endmodule

>>> hw/rtl/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_stat_t stat_i,
  output rau_pkg::rau_cmd_t  cmd_o
);

  rau_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::S_IDLE:  if (start) state_d = rau_pkg::S_MUL0;
      rau_pkg::S_MUL0:  state_d = stat_i.err_zero ? rau_pkg::S_FIN : rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:  state_d = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:  state_d = rau_pkg::S_COMB;
      rau_pkg::S_COMB:  state_d = rau_pkg::S_CHK;
      rau_pkg::S_CHK:   state_d = stat_i.n_zero ? rau_pkg::S_FIN : rau_pkg::S_GCD;
      rau_pkg::S_GCD:   if (stat_i.gcd_done) state_d = rau_pkg::S_DLOAD;
      rau_pkg::S_DLOAD: state_d = rau_pkg::S_DIV;
      rau_pkg::S_DIV:   if (stat_i.div_last) state_d = rau_pkg::S_FIN;
      rau_pkg::S_FIN:   state_d = rau_pkg::S_IDLE;
      default:          state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.mul_sel = rau_pkg::MUL_X;
    busy    = (state_q != rau_pkg::S_IDLE);
    case (state_q)
      rau_pkg::S_IDLE:  cmd_o.load = start;
      rau_pkg::S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_X;
      end
      rau_pkg::S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_D;
      end
      rau_pkg::S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rau_pkg::MUL_Y;
      end
      rau_pkg::S_COMB:  cmd_o.comb = 1'b1;
      rau_pkg::S_GCD:   cmd_o.gcd_step = 1'b1;
      rau_pkg::S_DLOAD: cmd_o.div_load = 1'b1;
      rau_pkg::S_DIV:   cmd_o.div_step = 1'b1;
      rau_pkg::S_FIN:   cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/rau_dp.sv
`timescale 1ns / 1ps
module rau_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rau_pkg::rau_cmd_t          cmd_i,
  output rau_pkg::rau_stat_t         stat_o,
  input  logic [1:0]                action_i,
  input  logic signed [rau_pkg::W-1:0] a_num_i,
  input  logic signed [rau_pkg::W-1:0] a_den_i,
  input  logic signed [rau_pkg::W-1:0] b_num_i,
  input  logic signed [rau_pkg::W-1:0] b_den_i,
  output logic                      valid_o,
  output logic signed [rau_pkg::W-1:0] res_num_o,
  output logic [rau_pkg::W-2:0]     res_den_o,
  output logic [1:0]                status_o
);

  localparam int unsigned W  = rau_pkg::W;
  localparam int unsigned DW = rau_pkg::DW;
  localparam int unsigned CW = rau_pkg::CW;

  rau_pkg::action_e act_q;
  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic          san_q, sad_q, sbn_q, sbd_q;
  logic [DW-1:0] p0_q, p1_q, p2_q;
  logic [DW-1:0] n_q, d_q, u_q, v_q;
  logic [DW-1:0] qn_q, qd_q, rn_q, rd_q;
  logic [CW-1:0] k_q, cnt_q;
  logic          neg_q;
  logic          valid_q;
  logic [W-1:0]  num_q;
  logic [W-2:0]  den_q;
  rau_pkg::status_e status_q;

  logic [W-1:0]  ma, mb;
  logic [DW-1:0] prod;
  logic [DW-1:0] n_c;
  logic          neg_c, sx, sy;
  logic [DW:0]   tn, td;
  logic          bit_n, bit_d;
  logic [DW-1:0] rn_c, rd_c;
  logic          ovf_n, ovf_d;

  assign stat_o.err_zero = (ad_q == '0) || (bd_q == '0) ||
                           ((act_q == rau_pkg::ACT_DIV) && (bn_q == '0));
  assign stat_o.n_zero   = (n_q == '0);
  assign stat_o.gcd_done = (u_q == v_q);
  assign stat_o.div_last = (cnt_q == CW'(DW - 1));

  always_comb begin
    case (cmd_i.mul_sel)
      rau_pkg::MUL_D: begin
        ma = ad_q;
        mb = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q;
      end
      rau_pkg::MUL_Y: begin
        ma = bn_q;
        mb = ad_q;
      end
      default: begin
        ma = an_q;
        mb = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
      end
    endcase
    prod = {{(DW-W){1'b0}}, ma} * {{(DW-W){1'b0}}, mb};
  end

  always_comb begin
    sx = san_q ^ sbd_q;
    sy = sbn_q ^ sad_q ^ (act_q == rau_pkg::ACT_SUB);
    if ((act_q == rau_pkg::ACT_ADD) || (act_q == rau_pkg::ACT_SUB)) begin
      if (sx == sy) begin
        n_c   = p0_q + p2_q;
        neg_c = sx ^ sad_q ^ sbd_q;
      end else if (p0_q >= p2_q) begin
        n_c   = p0_q - p2_q;
        neg_c = sx ^ sad_q ^ sbd_q;
      end else begin
        n_c   = p2_q - p0_q;
        neg_c = sy ^ sad_q ^ sbd_q;
      end
    end else begin
      n_c   = p0_q;
      neg_c = san_q ^ sbn_q ^ sad_q ^ sbd_q;
    end
  end

  always_comb begin
    tn    = {rn_q, qn_q[DW-1]};
    td    = {rd_q, qd_q[DW-1]};
    bit_n = (tn >= {1'b0, u_q});
    bit_d = (td >= {1'b0, u_q});
    rn_c  = bit_n ? DW'(tn - {1'b0, u_q}) : tn[DW-1:0];
    rd_c  = bit_d ? DW'(td - {1'b0, u_q}) : td[DW-1:0];
  end

  always_comb begin
    ovf_d = |qd_q[DW-1:W-1];
    if (neg_q) begin
      ovf_n = (|qn_q[DW-1:W]) || (qn_q[W-1] && (|qn_q[W-2:0]));
    end else begin
      ovf_n = |qn_q[DW-1:W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= rau_pkg::action_e'(action_i);
      an_q  <= rau_pkg::mag(a_num_i);
      ad_q  <= rau_pkg::mag(a_den_i);
      bn_q  <= rau_pkg::mag(b_num_i);
      bd_q  <= rau_pkg::mag(b_den_i);
      san_q <= a_num_i[W-1];
      sad_q <= a_den_i[W-1];
      sbn_q <= b_num_i[W-1];
      sbd_q <= b_den_i[W-1];
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        rau_pkg::MUL_X: p0_q <= prod;
        rau_pkg::MUL_D: p1_q <= prod;
        rau_pkg::MUL_Y: p2_q <= prod;
        default: ;
      endcase
    end
    if (cmd_i.comb) begin
      n_q   <= n_c;
      d_q   <= p1_q;
      u_q   <= n_c;
      v_q   <= p1_q;
      k_q   <= '0;
      neg_q <= neg_c;
    end
    if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + CW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q > v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else if (v_q > u_q) begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
    if (cmd_i.div_load) begin
      qn_q  <= n_q >> k_q;
      qd_q  <= d_q >> k_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rn_q  <= rn_c;
      rd_q  <= rd_c;
      qn_q  <= {qn_q[DW-2:0], bit_n};
      qd_q  <= {qd_q[DW-2:0], bit_d};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.finish) begin
      if (stat_o.err_zero) begin
        num_q    <= '0;
        den_q    <= '0;
        status_q <= rau_pkg::ST_ZERO_DEN;
      end else if (stat_o.n_zero) begin
        num_q    <= '0;
        den_q    <= (W-1)'(1);
        status_q <= rau_pkg::ST_OK;
      end else if (ovf_n || ovf_d) begin
        num_q    <= '0;
        den_q    <= '0;
        status_q <= rau_pkg::ST_TOO_WIDE;
      end else begin
        num_q    <= neg_q ? (~qn_q[W-1:0] + W'(1)) : qn_q[W-1:0];
        den_q    <= qd_q[W-2:0];
        status_q <= rau_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign valid_o   = valid_q;
  assign res_num_o = num_q;
  assign res_den_o = den_q;
  assign status_o  = status_q;

endmodule

>>> hw/rtl/rau_checker.sv
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"
module rau_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         valid_o,
  input logic signed [rau_pkg::W-1:0] res_num_o,
  input logic [rau_pkg::W-2:0]        res_den_o,
  input logic [1:0]                   status_o
);

  `RAU_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `RAU_ASSERT(a_strobe_single, valid_o |=> !valid_o)
  `RAU_ASSERT(a_ok_den, (valid_o && status_o == rau_pkg::ST_OK) |-> (res_den_o != '0))
  `RAU_ASSERT(a_err_zero, (valid_o && status_o != rau_pkg::ST_OK) |->
    (res_num_o == '0 && res_den_o == '0))
  `RAU_ASSERT_ANY(a_reset_quiet, !rst_ni |=> (!valid_o && !busy))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

>>> verif/rational_arithmetic_unit_test.sv
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;

  typedef struct {
    rau_pkg::action_e         act;
    logic [rau_pkg::W-1:0]    an, ad, bn, bd;
  } fraction_op_t;

  typedef struct {
    logic [rau_pkg::W-1:0]    num;
    logic [rau_pkg::W-2:0]    den;
    rau_pkg::status_e         st;
  } fraction_res_t;

  localparam longint unsigned HALF_W = 64'd1 << (rau_pkg::W - 1);
  localparam int MAX_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic signed [rau_pkg::W-1:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic valid_o;
  logic signed [rau_pkg::W-1:0] res_num_o;
  logic [rau_pkg::W-2:0] res_den_o;
  logic [1:0] status_o;

  fraction_op_t pending_ops[$];
  fraction_res_t expected_fracs[$];
  fraction_op_t cur_op;
  int gap_cycles = 0;
  int cycle_count = 0;
  int errors = 0;

  rational_arithmetic_unit dut (.*);

  initial forever #2 clk_i = ~clk_i;

  function automatic longint unsigned magnitude(input logic [rau_pkg::W-1:0] v,
                                                output bit neg);
    logic [rau_pkg::W-1:0] m;
    neg = v[rau_pkg::W-1];
    m = neg ? (~v + 1'b1) : v;
    return {32'd0, m};
  endfunction

  function automatic longint unsigned gcd64(input longint unsigned x, input longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_res_t reduce_fraction(input fraction_op_t op);
    fraction_res_t r;
    bit nan, nad, nbn, nbd, sx, sy, sn, neg;
    longint unsigned an, ad, bn, bd, x, y, n, d, g;
    an = magnitude(op.an, nan);
    ad = magnitude(op.ad, nad);
    bn = magnitude(op.bn, nbn);
    bd = magnitude(op.bd, nbd);
    r.num = '0;
    r.den = '0;
    r.st = rau_pkg::ST_ZERO_DEN;
    if (ad == 0 || bd == 0 || (op.act == rau_pkg::ACT_DIV && bn == 0)) return r;
    if (op.act == rau_pkg::ACT_ADD || op.act == rau_pkg::ACT_SUB) begin
      x = an * bd;
      y = bn * ad;
      sx = nan != nbd;
      sy = (nbn != nad) != (op.act == rau_pkg::ACT_SUB);
      if (sx == sy) begin
        n = x + y;
        sn = sx;
      end else if (x >= y) begin
        n = x - y;
        sn = sx;
      end else begin
        n = y - x;
        sn = sy;
      end
      d = ad * bd;
      neg = sn != (nad != nbd);
    end else if (op.act == rau_pkg::ACT_MUL) begin
      n = an * bn;
      d = ad * bd;
      neg = (nan != nbn) != (nad != nbd);
    end else begin
      n = an * bd;
      d = ad * bn;
      neg = (nan != nbd) != (nad != nbn);
    end
    r.st = rau_pkg::ST_OK;
    if (n == 0) begin
      r.den = (rau_pkg::W-1)'(1);
      return r;
    end
    g = gcd64(n, d);
    n = n / g;
    d = d / g;
    if (d > HALF_W - 1 || n > (neg ? HALF_W : HALF_W - 1)) begin
      r.st = rau_pkg::ST_TOO_WIDE;
      return r;
    end
    r.num = neg ? rau_pkg::W'(-n) : rau_pkg::W'(n);
    r.den = d[rau_pkg::W-2:0];
    return r;
  endfunction

  function automatic logic [rau_pkg::W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return rau_pkg::W'($urandom_range(0, 200)) - rau_pkg::W'(100);
      1, 2: return $urandom;
      3: return rau_pkg::W'($urandom_range(0, 131070)) - rau_pkg::W'(65535);
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      default: return rau_pkg::W'($urandom_range(1, 12)) * rau_pkg::W'($urandom_range(1, 360));
    endcase
  endfunction

  task automatic add_op(input rau_pkg::action_e act,
                        input logic [rau_pkg::W-1:0] an, ad, bn, bd);
    fraction_op_t op;
    op.act = act;
    op.an = an;
    op.ad = ad;
    op.bn = bn;
    op.bd = bd;
    pending_ops.push_back(op);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_fracs.push_back(reduce_fraction(cur_op));
        start <= 1'b0;
        gap_cycles <= $urandom_range(0, 10);
      end else if (!start) begin
        if (gap_cycles > 0) begin
          gap_cycles <= gap_cycles - 1;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          action_i <= cur_op.act;
          a_num_i <= cur_op.an;
          a_den_i <= cur_op.ad;
          b_num_i <= cur_op.bn;
          b_den_i <= cur_op.bd;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    fraction_res_t e;
    if (rst_ni && valid_o) begin
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
                 res_num_o, res_den_o, status_o);
        errors++;
      end else begin
        e = expected_fracs.pop_front();
        if (res_num_o !== e.num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, $signed(e.num), res_num_o);
          errors++;
        end
        if (res_den_o !== e.den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den_o);
          errors++;
        end
        if (status_o !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("rational_arithmetic_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    rau_pkg::action_e acts[4];
    acts = '{rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL, rau_pkg::ACT_DIV};
    foreach (acts[i]) begin
      add_op(acts[i], 32'd1, 32'd2, 32'd1, 32'd3);
      add_op(acts[i], 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      add_op(acts[i], -32'sd6, 32'd4, 32'd9, -32'sd6);
    end
    add_op(rau_pkg::ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    add_op(rau_pkg::ACT_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
    add_op(rau_pkg::ACT_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
    add_op(rau_pkg::ACT_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
    add_op(rau_pkg::ACT_MUL, 32'd0, -32'sd5, 32'd7, 32'd3);
    add_op(rau_pkg::ACT_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    add_op(rau_pkg::ACT_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    add_op(rau_pkg::ACT_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    add_op(rau_pkg::ACT_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
    add_op(rau_pkg::ACT_DIV, 32'd1, 32'd1, 32'd1, 32'h8000_0000);
    add_op(rau_pkg::ACT_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    repeat (1200) begin
      add_op(rau_pkg::action_e'($urandom_range(0, 3)), rand_word(), rand_word(),
             rand_word(), rand_word());
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && !start && expected_fracs.size() == 0);
    repeat (250) @(posedge clk_i);
    if (errors == 0 && expected_fracs.size() == 0) begin
      $display("rational_arithmetic_unit_test OK");
    end else begin
      $display("rational_arithmetic_unit_test NOT OK");
    end
    $finish;
  end

endmodule
